@@ hdl/bpe_pkg.sv @@
package bpe_pkg;

    // Default sizes
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 5;

    // Fixed datapath widths
    localparam int NUM_W  = 24;   // distance u*D - knot, Q16 units
    localparam int MUL_W  = 33;   // shared multiplier operand width
    localparam int PROD_W = 66;   // shared multiplier product width
    localparam int DIV_W  = 40;   // dividend width after the Q16 shift
    localparam int SPAN_W = 7;    // knot span in units of 1/D
    localparam int ACC_W  = 40;   // coordinate accumulators

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [16:0] U_ONE   = 17'h1_0000;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Register indexes
    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [16:0]        curve_param;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               status;
    } result_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_NEXT,
        S_WB,
        S_PT_RD,
        S_PT_X,
        S_PT_Y,
        S_PT_Z,
        S_PT_ACC,
        S_DONE
    } state_t;

    // Clamped uniform knot j, in units of 1/D
    function automatic logic [6:0] knot_units(input logic [7:0] j, input logic [2:0] p,
                                              input logic [6:0] n);
        logic [6:0] k;
        begin
            if (j <= {5'd0, p})
                k = 7'd0;
            else if (j >= {1'b0, n})
                k = n - {4'd0, p};
            else
                k = j[6:0] - {4'd0, p};
            return k;
        end
    endfunction

    // Saturate an accumulator to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF}))
                r = 32'sh7FFF_FFFF;
            else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000}))
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

@@ hdl/bspline_point_evaluation_core.sv @@
// Clamped uniform B-spline point evaluator. A command is taken when start is
// high and busy is low; busy then stays high until the result transaction,
// which is shown for exactly one cycle with done high and cannot be stalled.
// An evaluation runs one shared 33x33 multiplier and a
// one-bit-per-cycle 40-bit divider: each Cox-de Boor half term with a nonzero
// knot span is read, multiplied, divided and added, a skipped half term does
// no arithmetic, each basis value is then written back, and each control point
// is read, scaled and summed. The divider dominates the evaluation time.
module bspline_point_evaluation_core #(
    parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = bpe_pkg::MAX_DEGREE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bpe_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done,
    output bpe_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SD = MAX_DEGREE + 1;
    localparam int SW = (SD > 1) ? $clog2(SD) : 1;

    bpe_pkg::state_t state_reg, state_next;

    logic [2:0]  deg_reg;
    logic [6:0]  count_reg;
    logic [2:0]  p_use;
    logic [6:0]  n_use;
    logic [6:0]  d_use;

    logic [2:0]  r_reg, r_next;
    logic [2:0]  j_reg, j_next;
    logic        h_reg, h_next;
    logic [7:0]  s_reg, s_next;
    logic [bpe_pkg::NUM_W-1:0]  uu_reg, uu_next;
    logic [bpe_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [bpe_pkg::SPAN_W-1:0] span_reg, span_next;
    logic signed [bpe_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [31:0] acc_reg, acc_next;
    logic signed [bpe_pkg::ACC_W-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic        zero_reg, zero_next;
    logic        status_reg, status_next;

    // Scratch for basis values
    logic [31:0] scr_mem [SD];
    logic [31:0] scr_q_reg;
    logic        scr_we, scr_re;
    logic [SW-1:0] scr_waddr, scr_raddr;
    logic [31:0] scr_wdata;

    // Point store interface
    logic            pt_we, pt_re;
    logic [AW-1:0]   pt_raddr;
    bpe_pkg::point_t pt_wdata, pt_q;

    // Shared multiplier
    logic signed [bpe_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [bpe_pkg::PROD_W-1:0] mul_out;

    // Divider
    logic                       div_start, div_done;
    logic [bpe_pkg::DIV_W-1:0]  div_q;

    // Term addressing
    logic [7:0]  ti;
    logic [6:0]  tk0, tk1;
    logic        tvalid;
    logic [16:0] u_sat;
    logic [7:0]  sq, dm1;
    logic [7:0]  kidx;
    logic signed [bpe_pkg::ACC_W-1:0] contrib;

    // Register values in use
    always_comb
    begin
        if (deg_reg == 3'd0)
            p_use = 3'd1;
        else if (int'(deg_reg) > MAX_DEGREE)
            p_use = 3'(MAX_DEGREE);
        else
            p_use = deg_reg;
        if (int'(count_reg) > MAX_POINTS)
            n_use = 7'(MAX_POINTS);
        else
            n_use = count_reg;
        d_use = n_use - {4'd0, p_use};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg   <= 3'd3;
            count_reg <= 7'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpe_pkg::CFG_DEGREE: deg_reg   <= cfg_data[2:0];
                bpe_pkg::CFG_COUNT:  count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mul_out = mul_a * mul_b;

    assign pt_wdata.x = cmd.coord_x;
    assign pt_wdata.y = cmd.coord_y;
    assign pt_wdata.z = cmd.coord_z;

    bpe_point_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (pt_we),
        .waddr (AW'(cmd.point_index)),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_q)
    );

    bpe_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[bpe_pkg::DIV_W+15:16]),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Basis scratch memory
    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            scr_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_re)
        begin
            scr_q_reg <= scr_mem[scr_raddr];
        end
    end

    // Sequencer and datapath control
    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        j_next      = j_reg;
        h_next      = h_reg;
        s_next      = s_reg;
        uu_next     = uu_reg;
        num_next    = num_reg;
        span_next   = span_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        zero_next   = zero_reg;
        status_next = status_reg;
        scr_we      = 1'b0;
        scr_re      = 1'b0;
        scr_waddr   = SW'(j_reg);
        scr_raddr   = SW'(j_reg);
        scr_wdata   = acc_reg;
        pt_we       = 1'b0;
        pt_re       = 1'b0;
        div_start   = 1'b0;
        mul_a       = {1'b0, scr_q_reg};
        mul_b       = {{(bpe_pkg::MUL_W-bpe_pkg::NUM_W){1'b0}}, num_reg};

        u_sat = (cmd.curve_param > bpe_pkg::U_ONE) ? bpe_pkg::U_ONE : cmd.curve_param;
        sq    = 8'(uu_next >> 16);
        dm1   = {1'b0, d_use} - 8'd1;

        // knots of the current half term
        ti = s_reg - {5'd0, r_reg} + {5'd0, j_reg};
        if (!h_reg)
        begin
            tk0    = bpe_pkg::knot_units(ti, p_use, n_use);
            tk1    = bpe_pkg::knot_units(ti + {5'd0, r_reg}, p_use, n_use);
            tvalid = (j_reg != 3'd0);
        end
        else
        begin
            tk0    = bpe_pkg::knot_units(ti + 8'd1, p_use, n_use);
            tk1    = bpe_pkg::knot_units(ti + {5'd0, r_reg} + 8'd1, p_use, n_use);
            tvalid = (j_reg != r_reg);
        end
        kidx    = s_reg - {5'd0, p_use} + {5'd0, j_reg};
        pt_raddr = AW'(kidx);
        contrib = bpe_pkg::ACC_W'(prod_reg >>> 30);

        case (state_reg)
            bpe_pkg::S_IDLE:
            begin
                uu_next = uu_reg;
                if (start)
                begin
                    if (cmd.opcode == bpe_pkg::OP_LOAD)
                    begin
                        pt_we       = (int'(cmd.point_index) < MAX_POINTS);
                        zero_next   = 1'b1;
                        status_next = 1'b0;
                        state_next  = bpe_pkg::S_DONE;
                    end
                    else if (n_use <= {4'd0, p_use})
                    begin
                        zero_next   = 1'b1;
                        status_next = 1'b1;
                        state_next  = bpe_pkg::S_DONE;
                    end
                    else
                    begin
                        uu_next     = bpe_pkg::NUM_W'(u_sat) * bpe_pkg::NUM_W'(d_use);
                        sq          = 8'(uu_next >> 16);
                        s_next      = ((sq > dm1) ? dm1 : sq) + {5'd0, p_use};
                        scr_we      = 1'b1;
                        scr_waddr   = '0;
                        scr_wdata   = bpe_pkg::ONE_Q30;
                        r_next      = 3'd1;
                        j_next      = 3'd1;
                        h_next      = 1'b0;
                        acc_next    = '0;
                        ax_next     = '0;
                        ay_next     = '0;
                        az_next     = '0;
                        zero_next   = 1'b0;
                        status_next = 1'b0;
                        state_next  = bpe_pkg::S_TERM;
                    end
                end
            end
            bpe_pkg::S_TERM:
            begin
                if (tvalid && (tk1 > tk0))
                begin
                    if (!h_reg)
                        num_next = uu_reg - {1'b0, tk0, 16'd0};
                    else
                        num_next = {1'b0, tk1, 16'd0} - uu_reg;
                    span_next  = tk1 - tk0;
                    scr_re     = 1'b1;
                    scr_raddr  = h_reg ? SW'(j_reg) : SW'(j_reg - 3'd1);
                    state_next = bpe_pkg::S_MUL;
                end
                else
                begin
                    state_next = bpe_pkg::S_NEXT;
                end
            end
            bpe_pkg::S_MUL:
            begin
                prod_next  = mul_out;
                state_next = bpe_pkg::S_DIVGO;
            end
            bpe_pkg::S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = bpe_pkg::S_DIV;
            end
            bpe_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = acc_reg + div_q[31:0];
                    state_next = bpe_pkg::S_NEXT;
                end
            end
            bpe_pkg::S_NEXT:
            begin
                if (!h_reg)
                begin
                    h_next     = 1'b1;
                    state_next = bpe_pkg::S_TERM;
                end
                else
                begin
                    state_next = bpe_pkg::S_WB;
                end
            end
            bpe_pkg::S_WB:
            begin
                // basis values are updated in place from the top index down
                scr_we   = 1'b1;
                acc_next = '0;
                h_next   = 1'b0;
                if (j_reg == 3'd0)
                begin
                    if (r_reg == p_use)
                    begin
                        state_next = bpe_pkg::S_PT_RD;
                    end
                    else
                    begin
                        r_next     = r_reg + 3'd1;
                        j_next     = r_reg + 3'd1;
                        state_next = bpe_pkg::S_TERM;
                    end
                end
                else
                begin
                    j_next     = j_reg - 3'd1;
                    state_next = bpe_pkg::S_TERM;
                end
            end
            bpe_pkg::S_PT_RD:
            begin
                pt_re      = 1'b1;
                scr_re     = 1'b1;
                state_next = bpe_pkg::S_PT_X;
            end
            bpe_pkg::S_PT_X:
            begin
                mul_a      = {pt_q.x[31], pt_q.x};
                mul_b      = {1'b0, scr_q_reg};
                prod_next  = mul_out;
                state_next = bpe_pkg::S_PT_Y;
            end
            bpe_pkg::S_PT_Y:
            begin
                ax_next    = ax_reg + contrib;
                mul_a      = {pt_q.y[31], pt_q.y};
                mul_b      = {1'b0, scr_q_reg};
                prod_next  = mul_out;
                state_next = bpe_pkg::S_PT_Z;
            end
            bpe_pkg::S_PT_Z:
            begin
                ay_next    = ay_reg + contrib;
                mul_a      = {pt_q.z[31], pt_q.z};
                mul_b      = {1'b0, scr_q_reg};
                prod_next  = mul_out;
                state_next = bpe_pkg::S_PT_ACC;
            end
            bpe_pkg::S_PT_ACC:
            begin
                az_next = az_reg + contrib;
                if (j_reg == p_use)
                begin
                    state_next = bpe_pkg::S_DONE;
                end
                else
                begin
                    j_next     = j_reg + 3'd1;
                    state_next = bpe_pkg::S_PT_RD;
                end
            end
            bpe_pkg::S_DONE:
            begin
                state_next = bpe_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bpe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        j_reg      <= j_next;
        h_reg      <= h_next;
        s_reg      <= s_next;
        uu_reg     <= uu_next;
        num_reg    <= num_next;
        span_reg   <= span_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        zero_reg   <= zero_next;
        status_reg <= status_next;
    end

    // Result transaction
    assign busy          = (state_reg != bpe_pkg::S_IDLE);
    assign done          = (state_reg == bpe_pkg::S_DONE);
    assign result.out_x  = zero_reg ? 32'sd0 : bpe_pkg::sat32(ax_reg);
    assign result.out_y  = zero_reg ? 32'sd0 : bpe_pkg::sat32(ay_reg);
    assign result.out_z  = zero_reg ? 32'sd0 : bpe_pkg::sat32(az_reg);
    assign result.status = status_reg;

endmodule

@@ hdl/bpe_point_store.sv @@
module bpe_point_store #(
    parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_POINTS)-1:0] waddr,
    input  bpe_pkg::point_t               wdata,
    input  logic                          re,
    input  logic [$clog2(MAX_POINTS)-1:0] raddr,
    output bpe_pkg::point_t               rdata
);

    bpe_pkg::point_t mem [MAX_POINTS];
    bpe_pkg::point_t rdata_reg;

    // Control point storage, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bpe_divider.sv @@
module bpe_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bpe_pkg::DIV_W-1:0]      dividend,
    input  logic [bpe_pkg::SPAN_W-1:0]     divisor,
    output logic                           done,
    output logic [bpe_pkg::DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(bpe_pkg::DIV_W + 1);

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [bpe_pkg::DIV_W-1:0]    q_reg, q_next;
    logic [bpe_pkg::SPAN_W-1:0]   rem_reg, rem_next;
    logic [bpe_pkg::SPAN_W-1:0]   dsr_reg, dsr_next;
    logic [bpe_pkg::SPAN_W:0]     trial;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, q_reg[bpe_pkg::DIV_W-1]};
        if (start)
        begin
            cnt_next = CNT_W'(bpe_pkg::DIV_W);
            q_next   = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = bpe_pkg::SPAN_W'(trial - {1'b0, dsr_reg});
                q_next   = {q_reg[bpe_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[bpe_pkg::SPAN_W-1:0];
                q_next   = {q_reg[bpe_pkg::DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/bpe_checker.sv @@
module bpe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bpe_pkg::result_t result
);

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command accepted but block not busy");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // Busy drops only right after a result transaction
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // A too-few-points result carries the zero point
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> result.out_x == 0 && result.out_y == 0 &&
                                  result.out_z == 0)
        else $error("status set with a nonzero point");

endmodule

bind bspline_point_evaluation_core bpe_checker u_bpe_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
